// ===== src/clkdsp_pkg.sv =====
// clkdsp_pkg: shared types, constants and digit decode for the button-set clock
// used by every module of the block; depends on nothing
package clkdsp_pkg;

  localparam int TPS_W = 16;
  localparam int HOUR_W = 5;
  localparam int MIN_W = 7;
  localparam int SEC_W = 6;
  localparam int SEG_W = 8;

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;
  localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

  localparam logic [HOUR_W-1:0] HOUR_WRAP = 5'd24;
  localparam logic [MIN_W-1:0] MIN_WRAP = 7'd60;
  localparam logic [SEC_W-1:0] SEC_WRAP = 6'd60;
  localparam logic [HOUR_W-1:0] HOUR_PRESET = 5'd23;
  localparam logic [MIN_W-1:0] MIN_PRESET = 7'd59;
  localparam logic [SEC_W-1:0] SEC_PRESET = 6'd45;
  localparam logic [MIN_W-1:0] MIN_STEP = 7'd5;

  localparam logic MODE_HM = 1'b0;
  localparam logic MODE_MS = 1'b1;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              mode;
  } clkdsp_time_t;

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0: p = 8'h3F;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5B;
      4'd3: p = 8'h4F;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6D;
      4'd6: p = 8'h7D;
      4'd7: p = 8'h07;
      4'd8: p = 8'h7F;
      4'd9: p = 8'h6F;
      default: p = 8'h3F;
    endcase
    return p;
  endfunction

  // tens digit of a value below 100
  function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
    logic [3:0] t;
    priority if (v >= 7'd90) t = 4'd9;
    else if (v >= 7'd80) t = 4'd8;
    else if (v >= 7'd70) t = 4'd7;
    else if (v >= 7'd60) t = 4'd6;
    else if (v >= 7'd50) t = 4'd5;
    else if (v >= 7'd40) t = 4'd4;
    else if (v >= 7'd30) t = 4'd3;
    else if (v >= 7'd20) t = 4'd2;
    else if (v >= 7'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

endpackage

// ===== src/clkdsp_if.sv =====
// clkdsp_tick_if and clkdsp_result_if: valid/ready channels of the clock block
// depends on clkdsp_pkg for field widths
interface clkdsp_tick_if;
  logic valid;
  logic ready;
  logic push_level;
  logic left_level;
  logic right_level;
  logic front_level;
  logic back_level;

  modport source (output valid, push_level, left_level, right_level, front_level,
                  back_level, input ready);
  modport sink (input valid, push_level, left_level, right_level, front_level,
                back_level, output ready);
endinterface

interface clkdsp_result_if;
  import clkdsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] hour_value;
  logic [MIN_W-1:0]  minute_value;
  logic [SEC_W-1:0]  second_value;
  logic              display_mode;
  logic [SEG_W-1:0]  seg_first;
  logic [SEG_W-1:0]  seg_second;
  logic [SEG_W-1:0]  seg_third;
  logic [SEG_W-1:0]  seg_fourth;

  modport source (output valid, hour_value, minute_value, second_value, display_mode,
                  seg_first, seg_second, seg_third, seg_fourth, input ready);
  modport sink (input valid, hour_value, minute_value, second_value, display_mode,
                seg_first, seg_second, seg_third, seg_fourth, output ready);
endinterface

// ===== src/button_set_clock_with_display.sv =====
// button_set_clock_with_display: top level of the button-set clock
// depends on clkdsp_pkg, clkdsp_if, clkdsp_apb, clkdsp_time, clkdsp_seg
//
// usage: each word on the tick channel is one millisecond tick with five
// active-low button levels. the block answers every tick with one result word:
// time after the tick, display mode and four seven-segment patterns.
// ticks_per_second is written over the apb port at address 0 while idle.
// path: an accepted tick updates the clock state register, and its result word
// is decoded into the result register once the output side is free.
// throughput: one word per cycle while the receiver keeps ready high, set by
// the state update and the decode into the result register, which overlap.
// the block holds one decoded result in the output register and one undecoded
// state snapshot; ready drops only when both are occupied and the receiver
// stalls. nothing is lost while the receiver holds ready low.
// reset (synchronous, active high) clears the time, the tick counter and the
// button locks, selects minutes:seconds mode, sets ticks_per_second to 1000 and
// empties the output side.
module button_set_clock_with_display
  import clkdsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  clkdsp_tick_if.sink     tick,
  clkdsp_result_if.source result
);

  logic [TPS_W-1:0] ticks_per_second;
  clkdsp_time_t     time_now;
  logic             pend;
  logic             out_valid;
  logic             load_out;
  logic             accept;

  assign load_out = pend && (!out_valid || result.ready);
  assign tick.ready = !pend || load_out;
  assign accept = tick.valid && tick.ready;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= accept || (pend && !load_out);
      out_valid <= load_out || (out_valid && !result.ready);
    end
  end

  clkdsp_apb u_apb (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .ticks_per_second (ticks_per_second)
  );

  clkdsp_time u_time (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .ticks_per_second (ticks_per_second),
    .push_level       (tick.push_level),
    .left_level       (tick.left_level),
    .right_level      (tick.right_level),
    .front_level      (tick.front_level),
    .back_level       (tick.back_level),
    .time_now         (time_now)
  );

  clkdsp_seg u_seg (
    .clk          (clk),
    .load         (load_out),
    .time_now     (time_now),
    .hour_value   (result.hour_value),
    .minute_value (result.minute_value),
    .second_value (result.second_value),
    .display_mode (result.display_mode),
    .seg_first    (result.seg_first),
    .seg_second   (result.seg_second),
    .seg_third    (result.seg_third),
    .seg_fourth   (result.seg_fourth)
  );

endmodule

// ===== src/clkdsp_apb.sv =====
// clkdsp_apb: apb register port holding ticks_per_second
// depends on clkdsp_pkg
module clkdsp_apb
  import clkdsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [TPS_W-1:0] ticks_per_second
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      ticks_per_second <= pwdata[TPS_W-1:0];
    end
  end

  assign prdata = (paddr == 2'd0) ? {{(32-TPS_W){1'b0}}, ticks_per_second} : 32'd0;

endmodule

// ===== src/clkdsp_time.sv =====
// clkdsp_time: tick counter, time cascade, button locks and mode flag
// updated once per accepted word; depends on clkdsp_pkg
module clkdsp_time
  import clkdsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [TPS_W-1:0] ticks_per_second,
  input  logic             push_level,
  input  logic             left_level,
  input  logic             right_level,
  input  logic             front_level,
  input  logic             back_level,
  output clkdsp_time_t     time_now
);

  logic [TPS_W-1:0] tick_count, tick_count_next;
  clkdsp_time_t     time_next;
  logic [4:0]       lock, lock_next, press;
  logic [HOUR_W-1:0] h;
  logic [MIN_W-1:0]  m;
  logic [SEC_W-1:0]  s;
  logic              hit;
  logic              md;

  // lock bits: push, left, right, front, back
  assign lock_next = ~{push_level, left_level, right_level, front_level, back_level};
  assign press = lock_next & ~lock;

  always_comb begin
    hit = tick_count >= ticks_per_second;
    h = time_now.hour;
    m = time_now.minute;
    s = time_now.second;
    if (hit) s = s + 6'd1;
    if (s >= SEC_WRAP) begin
      m = m + 7'd1;
      s = '0;
    end
    if (m >= MIN_WRAP) begin
      h = h + 5'd1;
      m = '0;
      s = '0;
    end
    if (h >= HOUR_WRAP) begin
      h = '0;
      m = '0;
      s = '0;
    end
    if (press[4]) begin
      h = '0;
      m = '0;
      s = '0;
    end
    md = time_now.mode ^ press[3] ^ press[2];
    if (press[0]) begin
      h = HOUR_PRESET;
      m = MIN_PRESET;
      s = SEC_PRESET;
    end
    if (press[1]) begin
      if (md == MODE_MS) m = m + MIN_STEP;
      else h = h + 5'd1;
    end
    time_next = '{hour: h, minute: m, second: s, mode: md};
    tick_count_next = (hit ? '0 : tick_count) + {{(TPS_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      lock <= '0;
      time_now <= '{hour: '0, minute: '0, second: '0, mode: MODE_MS};
    end else if (step) begin
      tick_count <= tick_count_next;
      lock <= lock_next;
      time_now <= time_next;
    end
  end

endmodule

// ===== src/clkdsp_seg.sv =====
// clkdsp_seg: digit decode and result register
// depends on clkdsp_pkg
module clkdsp_seg
  import clkdsp_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  clkdsp_time_t      time_now,
  output logic [HOUR_W-1:0] hour_value,
  output logic [MIN_W-1:0]  minute_value,
  output logic [SEC_W-1:0]  second_value,
  output logic              display_mode,
  output logic [SEG_W-1:0]  seg_first,
  output logic [SEG_W-1:0]  seg_second,
  output logic [SEG_W-1:0]  seg_third,
  output logic [SEG_W-1:0]  seg_fourth
);

  logic [MIN_W-1:0] left_pair, right_pair;
  logic [3:0]       lt, rt;
  logic [MIN_W-1:0] lu, ru;

  always_comb begin
    if (time_now.mode == MODE_MS) begin
      left_pair = time_now.minute;
      right_pair = {1'b0, time_now.second};
    end else begin
      left_pair = {2'b00, time_now.hour};
      right_pair = time_now.minute;
    end
    lt = tens_of(left_pair);
    rt = tens_of(right_pair);
    lu = left_pair - MIN_W'(lt) * 7'd10;
    ru = right_pair - MIN_W'(rt) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hour_value <= time_now.hour;
      minute_value <= time_now.minute;
      second_value <= time_now.second;
      display_mode <= time_now.mode;
      seg_first <= digit_seg(lt);
      seg_second <= digit_seg(lu[3:0]) | DOT_BIT;
      seg_third <= digit_seg(rt);
      seg_fourth <= digit_seg(ru[3:0]);
    end
  end

endmodule
